/* sv/mer_pkg.sv */
// ----------------------------------------------------------------------------
// mer_pkg
// Shared codes and the command and status bundles that pass between the
// ellipse rasterizer controller and its datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

  // action field of an input item
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // operand pair for the shared multiplier
  typedef enum logic [3:0] {
    MUL_AA   = 4'd0,  // a * a
    MUL_BB   = 4'd1,  // b * b
    MUL_RXB  = 4'd2,  // a^2 * b
    MUL_P1   = 4'd3,  // b^2 * (x + 1)
    MUL_P2   = 4'd4,  // a^2 * (2y - 1)
    MUL_TT   = 4'd5,  // (2x + 1)^2
    MUL_UU   = 4'd6,  // (y - 1)^2
    MUL_RYT  = 4'd7,  // b^2 * tmp
    MUL_RXU  = 4'd8,  // a^2 * tmp
    MUL_RXRY = 4'd9   // a^2 * b^2
  } mul_sel_t;

  // update applied to the decision register
  typedef enum logic [2:0] {
    DEC_HOLD  = 3'd0,
    DEC_INIT  = 3'd1,
    DEC_MOVE1 = 3'd2,
    DEC_MOVE2 = 3'd3,
    DEC_LOADP = 3'd4,
    DEC_ADD4P = 3'd5,
    DEC_SUB4P = 3'd6
  } dec_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    dec_op_t  dec_op;
    logic     load_start;
    logic     ld_rxsq;
    logic     ld_rysq;
    logic     ld_p1;
    logic     ld_p2;
    logic     ld_tmp;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic lt;        // 2 * p1 < p2, still in region one
    logic y_zero;    // current y offset is zero
    logic out_free;  // output register can take a new item
  } status_t;

endpackage

/* sv/midpoint_ellipse_rasterizer.sv */
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// First-quadrant midpoint ellipse rasterizer, one point per step item.
// ----------------------------------------------------------------------------
// Input channel (step_valid / step_stall): an item with action start loads
// the center and both radii and yields the point (0, radius_y); an item
// with action step yields the next point of the arc. The point with
// offset_y zero carries last_point; later step items yield nothing.
// Output channel (plot_valid / plot_stall): one registered item per point.
// All products go through one shared registered multiplier, which sets the
// rate. A new item is taken only in idle, once the last one has gone to the
// output register. A start item walks SQA, SQB, RXB, DINIT and EMIT; a step
// walks P1, P2, CMP, MOVE1 or MOVE2 and EMIT, and the step that enters region
// two runs TSQ, USQ, RYT, RXU, RXRY and DFIN before MOVE2. A step after the
// arc has ended yields nothing. plot_valid is registered from EMIT.
// A result waits in the output register while the receiver stalls; the
// next item is accepted meanwhile and stops only when its own result is
// ready and the output register is still full.
// Reset (rst, synchronous) returns to idle with no arc running and clears
// plot_valid.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
  parameter int RADIUS_BITS = 11,
  parameter int COORD_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step_valid,
  output logic                          step_stall,
  input  logic                          action,
  input  logic signed [COORD_BITS-1:0]  center_x,
  input  logic signed [COORD_BITS-1:0]  center_y,
  input  logic        [RADIUS_BITS-1:0] radius_x,
  input  logic        [RADIUS_BITS-1:0] radius_y,
  output logic                          plot_valid,
  input  logic                          plot_stall,
  output logic signed [COORD_BITS-1:0]  plot_center_x,
  output logic signed [COORD_BITS-1:0]  plot_center_y,
  output logic        [RADIUS_BITS-1:0] offset_x,
  output logic        [RADIUS_BITS-1:0] offset_y,
  output logic                          last_point
);

  mer_pkg::cmd_t    cmd;
  mer_pkg::status_t status;

  mer_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .action     (action),
    .status     (status),
    .step_stall (step_stall),
    .cmd        (cmd)
  );

  mer_datapath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .center_x      (center_x),
    .center_y      (center_y),
    .radius_x      (radius_x),
    .radius_y      (radius_y),
    .plot_stall    (plot_stall),
    .plot_valid    (plot_valid),
    .plot_center_x (plot_center_x),
    .plot_center_y (plot_center_y),
    .offset_x      (offset_x),
    .offset_y      (offset_y),
    .last_point    (last_point)
  );

endmodule

/* sv/mer_ctrl.sv */
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer for the ellipse rasterizer: accepts items, walks the shared
// multiplier through each item's products and hands results to the output.
// ----------------------------------------------------------------------------
module mer_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_valid,
  input  logic              action,
  input  mer_pkg::status_t  status,
  output logic              step_stall,
  output mer_pkg::cmd_t     cmd
);

  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_SQA   = 17'h00002,
    ST_SQB   = 17'h00004,
    ST_RXB   = 17'h00008,
    ST_DINIT = 17'h00010,
    ST_P1    = 17'h00020,
    ST_P2    = 17'h00040,
    ST_CMP   = 17'h00080,
    ST_MOVE1 = 17'h00100,
    ST_MOVE2 = 17'h00200,
    ST_TSQ   = 17'h00400,
    ST_USQ   = 17'h00800,
    ST_RYT   = 17'h01000,
    ST_RXU   = 17'h02000,
    ST_RXRY  = 17'h04000,
    ST_DFIN  = 17'h08000,
    ST_EMIT  = 17'h10000
  } state_t;

  state_t state, state_next;
  logic   busy, busy_next;
  logic   region_two, region_two_next;

  assign step_stall = (state != ST_IDLE);

  always_comb begin
    state_next      = state;
    busy_next       = busy;
    region_two_next = region_two;
    cmd.mul_sel     = mer_pkg::MUL_AA;
    cmd.dec_op      = mer_pkg::DEC_HOLD;
    cmd.load_start  = 1'b0;
    cmd.ld_rxsq     = 1'b0;
    cmd.ld_rysq     = 1'b0;
    cmd.ld_p1       = 1'b0;
    cmd.ld_p2       = 1'b0;
    cmd.ld_tmp      = 1'b0;
    cmd.emit        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (step_valid) begin
          if (action == mer_pkg::ACT_START) begin
            cmd.load_start  = 1'b1;
            region_two_next = 1'b0;
            state_next      = ST_SQA;
          end else if (busy) begin
            state_next = ST_P1;
          end
        end
      end
      ST_SQA: begin
        cmd.mul_sel = mer_pkg::MUL_AA;
        state_next  = ST_SQB;
      end
      ST_SQB: begin
        cmd.mul_sel = mer_pkg::MUL_BB;
        cmd.ld_rxsq = 1'b1;
        state_next  = ST_RXB;
      end
      ST_RXB: begin
        cmd.mul_sel = mer_pkg::MUL_RXB;
        cmd.ld_rysq = 1'b1;
        state_next  = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.dec_op = mer_pkg::DEC_INIT;
        state_next = ST_EMIT;
      end
      ST_P1: begin
        cmd.mul_sel = mer_pkg::MUL_P1;
        state_next  = ST_P2;
      end
      ST_P2: begin
        cmd.mul_sel = mer_pkg::MUL_P2;
        cmd.ld_p1   = 1'b1;
        state_next  = ST_CMP;
      end
      ST_CMP: begin
        cmd.ld_p2 = 1'b1;
        priority if (region_two) begin
          state_next = ST_MOVE2;
        end else if (status.lt) begin
          state_next = ST_MOVE1;
        end else begin
          region_two_next = 1'b1;
          state_next      = ST_TSQ;
        end
      end
      ST_MOVE1: begin
        cmd.dec_op = mer_pkg::DEC_MOVE1;
        state_next = ST_EMIT;
      end
      ST_MOVE2: begin
        cmd.dec_op = mer_pkg::DEC_MOVE2;
        state_next = ST_EMIT;
      end
      // region two starting value, one product per cycle
      ST_TSQ: begin
        cmd.mul_sel = mer_pkg::MUL_TT;
        state_next  = ST_USQ;
      end
      ST_USQ: begin
        cmd.mul_sel = mer_pkg::MUL_UU;
        cmd.ld_tmp  = 1'b1;
        state_next  = ST_RYT;
      end
      ST_RYT: begin
        cmd.mul_sel = mer_pkg::MUL_RYT;
        cmd.ld_tmp  = 1'b1;
        state_next  = ST_RXU;
      end
      ST_RXU: begin
        cmd.mul_sel = mer_pkg::MUL_RXU;
        cmd.dec_op  = mer_pkg::DEC_LOADP;
        state_next  = ST_RXRY;
      end
      ST_RXRY: begin
        cmd.mul_sel = mer_pkg::MUL_RXRY;
        cmd.dec_op  = mer_pkg::DEC_ADD4P;
        state_next  = ST_DFIN;
      end
      ST_DFIN: begin
        cmd.dec_op = mer_pkg::DEC_SUB4P;
        state_next = ST_MOVE2;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          busy_next  = !status.y_zero;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      busy       <= 1'b0;
      region_two <= 1'b0;
    end else begin
      state      <= state_next;
      busy       <= busy_next;
      region_two <= region_two_next;
    end
  end

endmodule

/* sv/mer_datapath.sv */
// ----------------------------------------------------------------------------
// mer_datapath
// Arc registers, squared radii, decision variable, one shared registered
// multiplier and the output register of the ellipse rasterizer.
// ----------------------------------------------------------------------------
module mer_datapath #(
  parameter int RADIUS_BITS = 11,
  parameter int COORD_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mer_pkg::cmd_t                 cmd,
  output mer_pkg::status_t              status,
  input  logic signed [COORD_BITS-1:0]  center_x,
  input  logic signed [COORD_BITS-1:0]  center_y,
  input  logic        [RADIUS_BITS-1:0] radius_x,
  input  logic        [RADIUS_BITS-1:0] radius_y,
  input  logic                          plot_stall,
  output logic                          plot_valid,
  output logic signed [COORD_BITS-1:0]  plot_center_x,
  output logic signed [COORD_BITS-1:0]  plot_center_y,
  output logic        [RADIUS_BITS-1:0] offset_x,
  output logic        [RADIUS_BITS-1:0] offset_y,
  output logic                          last_point
);

  localparam int RB  = RADIUS_BITS;
  localparam int SQ  = 2 * RB;       // squared radius
  localparam int MA  = SQ;           // multiplier operand a
  localparam int MB  = SQ + 2;       // multiplier operand b
  localparam int PW  = MA + MB;      // product
  localparam int P1W = 3 * RB + 1;   // b^2 (x+1) and a^2 (2y-1)
  localparam int DW  = 4 * RB + 4;   // decision, two's complement

  logic        [RB-1:0]         cur_x, cur_y, rad_x;
  logic        [SQ-1:0]         rxsq, rysq;
  logic signed [COORD_BITS-1:0] held_x, held_y;
  logic        [DW-1:0]         decision;
  logic        [PW-1:0]         prod;
  logic        [P1W-1:0]        p1, p2;
  logic        [MB-1:0]         tmp;

  logic [RB:0]     x_inc, y_twice_m1, t_val;
  logic [RB-1:0]   u_val;
  logic [MA-1:0]   mul_a;
  logic [MB-1:0]   mul_b;
  logic [PW-1:0]   mul_p;
  logic [DW-1:0]   xa4, ym4, ya4, p1x8, init_val, prod4;
  logic            dec_neg;
  logic            x_full;

  assign x_inc      = {1'b0, cur_x} + (RB+1)'(1);
  assign y_twice_m1 = {cur_y, 1'b0} - (RB+1)'(1);
  assign t_val      = {cur_x, 1'b1};
  assign u_val      = cur_y - RB'(1);
  assign x_full     = (cur_x == {RB{1'b1}});
  assign dec_neg    = decision[DW-1];

  always_comb begin
    unique case (cmd.mul_sel)
      mer_pkg::MUL_AA: begin
        mul_a = MA'(rad_x);
        mul_b = MB'(rad_x);
      end
      mer_pkg::MUL_BB: begin
        mul_a = MA'(cur_y);
        mul_b = MB'(cur_y);
      end
      mer_pkg::MUL_RXB: begin
        mul_a = rxsq;
        mul_b = MB'(cur_y);
      end
      mer_pkg::MUL_P1: begin
        mul_a = rysq;
        mul_b = MB'(x_inc);
      end
      mer_pkg::MUL_P2: begin
        mul_a = rxsq;
        mul_b = MB'(y_twice_m1);
      end
      mer_pkg::MUL_TT: begin
        mul_a = MA'(t_val);
        mul_b = MB'(t_val);
      end
      mer_pkg::MUL_UU: begin
        mul_a = MA'(u_val);
        mul_b = MB'(u_val);
      end
      mer_pkg::MUL_RYT: begin
        mul_a = rysq;
        mul_b = tmp;
      end
      mer_pkg::MUL_RXU: begin
        mul_a = rxsq;
        mul_b = tmp;
      end
      mer_pkg::MUL_RXRY: begin
        mul_a = rxsq;
        mul_b = MB'(rysq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // decision increments and starting values, all scaled by four
  assign xa4      = (DW'(p1) << 3) + (DW'(rysq) << 2);
  assign ym4      = (DW'(rxsq) - DW'(p2)) << 2;
  assign ya4      = ((DW'(rxsq) << 1) - DW'(p2)) << 2;
  assign p1x8     = DW'(p1) << 3;
  assign init_val = (DW'(rysq) << 2) - (DW'(prod) << 2) + DW'(rxsq);
  assign prod4    = DW'(prod) << 2;

  assign status.lt       = ({p1, 1'b0} < {1'b0, prod[P1W-1:0]});
  assign status.y_zero   = (cur_y == '0);
  assign status.out_free = !plot_valid || !plot_stall;

  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (cmd.ld_rxsq) begin
      rxsq <= prod[SQ-1:0];
    end
    if (cmd.ld_rysq) begin
      rysq <= prod[SQ-1:0];
    end
    if (cmd.ld_p1) begin
      p1 <= prod[P1W-1:0];
    end
    if (cmd.ld_p2) begin
      p2 <= prod[P1W-1:0];
    end
    if (cmd.ld_tmp) begin
      tmp <= prod[MB-1:0];
    end
    if (cmd.load_start) begin
      held_x <= center_x;
      held_y <= center_y;
      rad_x  <= radius_x;
      cur_x  <= '0;
      cur_y  <= radius_y;
    end
    unique case (cmd.dec_op)
      mer_pkg::DEC_HOLD: begin
      end
      mer_pkg::DEC_INIT: begin
        decision <= init_val;
      end
      mer_pkg::DEC_MOVE1: begin
        if (dec_neg) begin
          decision <= decision + xa4;
        end else begin
          decision <= decision + xa4 + ym4;
          cur_y    <= cur_y - RB'(1);
        end
        if (!x_full) begin
          cur_x <= cur_x + RB'(1);
        end
      end
      mer_pkg::DEC_MOVE2: begin
        if (dec_neg) begin
          decision <= decision + p1x8 + ya4;
          if (!x_full) begin
            cur_x <= cur_x + RB'(1);
          end
        end else begin
          decision <= decision + ya4;
        end
        cur_y <= cur_y - RB'(1);
      end
      mer_pkg::DEC_LOADP: begin
        decision <= DW'(prod);
      end
      mer_pkg::DEC_ADD4P: begin
        decision <= decision + prod4;
      end
      mer_pkg::DEC_SUB4P: begin
        decision <= decision - prod4;
      end
      default: begin
      end
    endcase
  end

  // output register, holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      plot_valid <= 1'b0;
    end else if (cmd.emit) begin
      plot_valid <= 1'b1;
    end else if (!plot_stall) begin
      plot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      plot_center_x <= held_x;
      plot_center_y <= held_y;
      offset_x      <= cur_x;
      offset_y      <= cur_y;
      last_point    <= (cur_y == '0);
    end
  end

endmodule

/* sv/mer_checker.sv */
// ----------------------------------------------------------------------------
// mer_checker
// Port-level checks for the ellipse rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module mer_checker #(
  parameter int RADIUS_BITS = 11,
  parameter int COORD_BITS  = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          step_valid,
  input logic                          step_stall,
  input logic                          action,
  input logic                          plot_valid,
  input logic                          plot_stall,
  input logic signed [COORD_BITS-1:0]  plot_center_x,
  input logic signed [COORD_BITS-1:0]  plot_center_y,
  input logic        [RADIUS_BITS-1:0] offset_x,
  input logic        [RADIUS_BITS-1:0] offset_y,
  input logic                          last_point
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    plot_valid && plot_stall |=> plot_valid && $stable(offset_x) && $stable(offset_y)
      && $stable(plot_center_x) && $stable(plot_center_y) && $stable(last_point))
    else $error("stalled plot item changed");

  // only the point on the x axis ends the arc
  a_last: assert property (@(posedge clk) disable iff (rst)
    plot_valid |-> (last_point == (offset_y == '0)))
    else $error("last_point does not match offset_y");

  // a start item always keeps the sequencer busy for the next cycle
  a_start: assert property (@(posedge clk) disable iff (rst)
    step_valid && !step_stall && (action == mer_pkg::ACT_START) |=> step_stall)
    else $error("start item did not occupy the block");

  // a new result leaves the block ready for the next item
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(plot_valid) |-> !step_stall)
    else $error("block not ready after emitting a point");

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(
  .RADIUS_BITS (RADIUS_BITS),
  .COORD_BITS  (COORD_BITS)
) u_mer_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-quadrant midpoint ellipse rasterizer.
// Start and step items go in on the step channel. A cycle-free predictor
// walks the same arc in integer arithmetic and queues the points it expects.
// Each point taken from the plot channel is compared field by field with the
// oldest queued point. Both channels idle and stall in random bursts, and
// one long output hold fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RB = 11;
  localparam int CB = 16;

  typedef struct {
    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
    logic        [RB-1:0] ox;
    logic        [RB-1:0] oy;
    logic                 last;
  } plot_point_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 step_valid = 1'b0;
  logic                 step_stall;
  logic                 action = mer_pkg::ACT_STEP;
  logic signed [CB-1:0] center_x = '0;
  logic signed [CB-1:0] center_y = '0;
  logic        [RB-1:0] radius_x = '0;
  logic        [RB-1:0] radius_y = '0;
  logic                 plot_valid;
  logic                 plot_stall = 1'b0;
  logic signed [CB-1:0] plot_center_x;
  logic signed [CB-1:0] plot_center_y;
  logic        [RB-1:0] offset_x;
  logic        [RB-1:0] offset_y;
  logic                 last_point;

  // arc state as the predictor sees it
  logic                 arc_busy = 1'b0;
  logic                 arc_region_two = 1'b0;
  logic        [RB-1:0] pen_x = '0;
  logic        [RB-1:0] pen_y = '0;
  longint               err_term = 0;
  longint               rx_sq = 0;
  longint               ry_sq = 0;
  logic signed [CB-1:0] hold_cx = '0;
  logic signed [CB-1:0] hold_cy = '0;

  plot_point_t expected_points[$];
  int          fail_count = 0;
  int          items_sent = 0;
  bit          idle_enable = 1'b1;
  bit          stall_enable = 1'b1;
  int          hold_cycles_req = 0;

  midpoint_ellipse_rasterizer #(
    .RADIUS_BITS(RB),
    .COORD_BITS (CB)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .step_valid   (step_valid),
    .step_stall   (step_stall),
    .action       (action),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius_x     (radius_x),
    .radius_y     (radius_y),
    .plot_valid   (plot_valid),
    .plot_stall   (plot_stall),
    .plot_center_x(plot_center_x),
    .plot_center_y(plot_center_y),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .last_point   (last_point)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function void queue_point(logic last);
    expected_points.push_back('{hold_cx, hold_cy, pen_x, pen_y, last});
  endfunction

  function void bump_x();
    if (pen_x != {RB{1'b1}}) pen_x = pen_x + 1'b1;
  endfunction

  // y always falls in region two, x moves when the midpoint is inside
  function void region_two_move();
    longint x, y, ya;
    x = pen_x;
    y = pen_y;
    ya = 4 * rx_sq * (3 - 2 * y);
    if (err_term < 0) begin
      err_term = err_term + 4 * ry_sq * (2 * x + 2) + ya;
      bump_x();
    end else begin
      err_term = err_term + ya;
    end
    pen_y = pen_y - 1'b1;
  endfunction

  function void rasterize_item(logic act, logic signed [CB-1:0] cx,
                               logic signed [CB-1:0] cy, logic [RB-1:0] rx,
                               logic [RB-1:0] ry);
    longint a, b, x, y, xa, t, u;
    if (act == mer_pkg::ACT_START) begin
      a = rx;
      b = ry;
      hold_cx = cx;
      hold_cy = cy;
      rx_sq = a * a;
      ry_sq = b * b;
      err_term = 4 * ry_sq - 4 * rx_sq * b + rx_sq;
      pen_x = '0;
      pen_y = ry;
      arc_region_two = 1'b0;
      arc_busy = (ry != 0);
      queue_point(ry == 0);
      return;
    end
    if (!arc_busy) return;
    if (!arc_region_two) begin
      x = pen_x;
      y = pen_y;
      if (2 * ry_sq * (x + 1) < rx_sq * (2 * y - 1)) begin
        xa = 4 * ry_sq * (2 * x + 3);
        if (err_term < 0) begin
          err_term = err_term + xa;
        end else begin
          err_term = err_term + xa + 4 * rx_sq * (2 - 2 * y);
          pen_y = pen_y - 1'b1;
        end
        bump_x();
      end else begin
        // crossing into region two: fresh decision, then its first move
        t = 2 * x + 1;
        u = y - 1;
        arc_region_two = 1'b1;
        err_term = ry_sq * t * t + 4 * rx_sq * u * u - 4 * rx_sq * ry_sq;
        region_two_move();
      end
    end else begin
      region_two_move();
    end
    if (pen_y == 0) arc_busy = 1'b0;
    queue_point(pen_y == 0);
  endfunction

  // ------------------------------------------------------------------ sender

  task automatic send_item(input logic act, input logic signed [CB-1:0] cx,
                           input logic signed [CB-1:0] cy, input logic [RB-1:0] rx,
                           input logic [RB-1:0] ry);
    if (idle_enable && $urandom_range(0, 9) == 0) begin
      step_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    step_valid <= 1'b1;
    action     <= act;
    center_x   <= cx;
    center_y   <= cy;
    radius_x   <= rx;
    radius_y   <= ry;
    @(posedge clk);
    while (step_stall) @(posedge clk);
    if (act == mer_pkg::ACT_START || arc_busy) items_sent++;
    rasterize_item(act, cx, cy, rx, ry);
  endtask

  // step items carry junk in the unused fields
  task automatic send_step();
    send_item(mer_pkg::ACT_STEP, CB'($urandom), CB'($urandom), RB'($urandom),
              RB'($urandom));
  endtask

  task automatic run_arc(input logic signed [CB-1:0] cx, input logic signed [CB-1:0] cy,
                         input logic [RB-1:0] rx, input logic [RB-1:0] ry,
                         input int max_steps, input int extra);
    int k;
    k = 0;
    send_item(mer_pkg::ACT_START, cx, cy, rx, ry);
    while (arc_busy && k < max_steps) begin
      send_step();
      k++;
    end
    repeat (extra) send_step();
  endtask

  // ----------------------------------------------------------------- receiver

  initial begin : plot_receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_cycles_req != 0) begin
        n = hold_cycles_req;
        hold_cycles_req = 0;
        plot_stall <= 1'b1;
        repeat (n) @(posedge clk);
        plot_stall <= 1'b0;
      end else if (stall_enable && $urandom_range(0, 11) == 0) begin
        plot_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        plot_stall <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string what, input plot_point_t want);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: exp (%0d,%0d) (%0d,%0d) %0b, got (%0d,%0d) (%0d,%0d) %0b",
               $realtime, what, want.cx, want.cy, want.ox, want.oy, want.last,
               plot_center_x, plot_center_y, offset_x, offset_y, last_point);
  endtask

  always @(posedge clk) begin : plot_checker
    plot_point_t want;
    if (!rst && plot_valid && !plot_stall) begin
      if (expected_points.size() == 0) begin
        want = '{'0, '0, '0, '0, 1'b0};
        report_mismatch("point with none pending", want);
      end else begin
        want = expected_points.pop_front();
        if (plot_center_x !== want.cx || plot_center_y !== want.cy ||
            offset_x !== want.ox || offset_y !== want.oy || last_point !== want.last)
          report_mismatch("point differs", want);
      end
    end
  end

  // -------------------------------------------------------------------- tests

  task automatic test_directed();
    // big arc with corner centers, abandoned by a zero-size start
    run_arc(16'sh7FFF, -16'sh8000, 11'h7FF, 11'h7FF, 3, 0);
    run_arc(-16'sh8000, 16'sh7FFF, 11'h000, 11'h000, 0, 2);
    // no x radius: region two from the first step
    run_arc(16'sh0000, -16'sh0001, 11'h000, 11'd3, 10, 1);
    run_arc(16'sh1234, 16'sh5A5A, 11'd3, 11'd2, 10, 1);
    run_arc(-16'sh0100, 16'sh00FF, 11'd1, 11'd1, 10, 0);
    // flat and tall extremes, cut short
    run_arc(16'sh2AAA, -16'sh5555, 11'h7FF, 11'd1, 3, 0);
    run_arc(-16'sh2AAB, 16'sh5554, 11'd1, 11'h7FF, 2, 0);
  endtask

  task automatic test_output_backpressure();
    hold_cycles_req = 300;
    run_arc(CB'($urandom), CB'($urandom), 11'd40, 11'd30, 20, 0);
  endtask

  task automatic test_random_arcs(input int budget);
    int          target, pick, cap;
    logic [RB-1:0] rx, ry;
    target = items_sent + budget;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_item(1'($urandom_range(0, 1)), CB'($urandom), CB'($urandom),
                  RB'($urandom), RB'($urandom));
      end else begin
        if (pick < 20) begin
          // full-range radii, cut short to keep the run bounded
          rx = RB'($urandom);
          ry = RB'($urandom);
          cap = $urandom_range(2, 40);
        end else begin
          rx = RB'($urandom_range(0, 48));
          ry = RB'($urandom_range(1, 48));
          cap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20) : 100000;
        end
        run_arc(CB'($urandom), CB'($urandom), rx, ry, cap, $urandom_range(0, 2));
      end
    end
  endtask

  initial begin : main_sequence
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_output_backpressure();
    test_random_arcs(1200);
    idle_enable = 1'b0;
    stall_enable = 1'b0;
    test_random_arcs(200);
    step_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (expected_points.size() != 0) fail_count++;
    if (fail_count == 0)
      $display("midpoint_ellipse_rasterizer: match");
    else
      $display("midpoint_ellipse_rasterizer: mismatch");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("midpoint_ellipse_rasterizer: mismatch");
    $finish;
  end

endmodule

/* sim.f */
sv/mer_pkg.sv
sv/mer_ctrl.sv
sv/mer_datapath.sv
sv/midpoint_ellipse_rasterizer.sv
sv/mer_checker.sv
tb/sv/tb_top.sv
